### hdl/mrfc_pkg.sv
// ---------------------------------------------------------------------------
// mrfc_pkg: shared types and constants
// Beat types, status codes, function codes and the CRC-16/Modbus byte update
// used by the response frame checker.
// ---------------------------------------------------------------------------
`default_nettype none

package mrfc_pkg;

   localparam int COUNT_BITS_DEFAULT = 9;
   localparam int EXP_BITS           = 9;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   localparam logic [7:0] FC_READ     = 8'h03;
   localparam logic [7:0] FC_WRITE1   = 8'h06;
   localparam logic [7:0] FC_WRITEN   = 8'h10;
   localparam logic [7:0] FC_READ_EXC = 8'h83;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

   localparam logic [EXP_BITS-1:0] LEN_MIN       = EXP_BITS'(5);
   localparam logic [EXP_BITS-1:0] LEN_WRITE     = EXP_BITS'(8);
   localparam logic [EXP_BITS-1:0] LEN_EXCEPTION = EXP_BITS'(5);
   localparam logic [EXP_BITS-1:0] LEN_READ_BASE = EXP_BITS'(5);

   typedef enum logic [2:0] {
      STATUS_VALID       = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_ADDRESS = 3'd2,
      STATUS_UNKNOWN_FC  = 3'd3,
      STATUS_MISSING     = 3'd4,
      STATUS_CRC_ERROR   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      status_type status;
      logic       extra_bytes;
      logic [7:0] function_code;
   } rsp_beat_type;

   // reflected crc-16, one byte folded in over eight shift steps
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hdl/modbus_response_frame_checker.sv
// ---------------------------------------------------------------------------
// modbus_response_frame_checker: modbus rtu response length and crc check
// Takes the bytes of one received response, one per beat, and gives one
// verdict beat for each frame on the beat flagged as its last byte.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              beat contents
//  req_      in         req_valid / req_ready  rx_byte, last_byte
//  rsp_      out        rsp_valid / rsp_ready  status, extra_bytes, function_code
//  csr_      in         csr_write_enable       slave_address (8 bits)
//
//  one byte accepted every cycle while req_ready is high; the crc byte update
//  is a single shift/xor pass between the frame state and the result register
//  a verdict on rsp_ comes from the output slot register, via skid if it is held
//  req_ready drops only while both result slots (output + skid) are full
//  synchronous reset clears frame state, empties the result slots and sets
//  slave_address to 1; no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_response_frame_checker
   import mrfc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // byte input
   input  wire logic       req_valid,
   output logic            req_ready,
   input  req_beat_type    req_data,
   // verdict output
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_beat_type    rsp_data,
   // register write
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0]   slave_address_ff;
   logic         beat_accept;
   logic         result_valid;
   rsp_beat_type result_data;
   logic         has_room;

   // expected device address
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         slave_address_ff <= csr_write_data;
      end
   end

   // any byte may end a frame, so room for one verdict is needed
   assign req_ready   = has_room;
   assign beat_accept = req_valid && req_ready;

   mrfc_frame_track #(
      .COUNT_BITS(COUNT_BITS)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .beat_data    (req_data),
      .slave_address(slave_address_ff),
      .result_valid (result_valid),
      .result_data  (result_data)
   );

   mrfc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(result_valid),
      .push_data (result_data),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/mrfc_frame_track.sv
// ---------------------------------------------------------------------------
// mrfc_frame_track: per-frame state and verdict
// Latches address, function and crc bytes, runs the crc and forms the
// verdict on the last byte of a frame.
// ---------------------------------------------------------------------------
`default_nettype none

module mrfc_frame_track
   import mrfc_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         beat_accept,
   input  req_beat_type      beat_data,
   input  wire logic [7:0]   slave_address,
   output logic              result_valid,
   output rsp_beat_type      result_data
);

   localparam int EXT_BITS = COUNT_BITS + 1;

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic [15:0]           running_crc_ff, running_crc_in;
   logic [7:0]            first_byte_ff, first_byte_in;
   logic [7:0]            func_byte_ff, func_byte_in;
   logic [EXP_BITS-1:0]   expected_total_ff, expected_total_in;
   logic                  function_known_ff, function_known_in;
   logic [7:0]            crc_low_rx_ff, crc_low_rx_in;
   logic [7:0]            crc_high_rx_ff, crc_high_rx_in;

   logic [EXT_BITS-1:0]   idx_plus2, idx_plus1, exp_ext, count_ext;
   logic [7:0]            b;

   assign b = beat_data.rx_byte;

   always_comb begin
      byte_count_in     = byte_count_ff;
      running_crc_in    = running_crc_ff;
      first_byte_in     = first_byte_ff;
      func_byte_in      = func_byte_ff;
      expected_total_in = expected_total_ff;
      function_known_in = function_known_ff;
      crc_low_rx_in     = crc_low_rx_ff;
      crc_high_rx_in    = crc_high_rx_ff;

      // header capture and expected length
      if (byte_count_ff == '0) begin
         first_byte_in = b;
      end else if (byte_count_ff == COUNT_BITS'(1)) begin
         func_byte_in = b;
         priority if (b == FC_READ) begin
            function_known_in = 1'b1;
         end else if (b == FC_WRITE1 || b == FC_WRITEN) begin
            function_known_in = 1'b1;
            expected_total_in = LEN_WRITE;
         end else if (b == FC_READ_EXC) begin
            function_known_in = 1'b1;
            expected_total_in = LEN_EXCEPTION;
         end else begin
            function_known_in = 1'b0;
         end
      end else if (byte_count_ff == COUNT_BITS'(2) && func_byte_ff == FC_READ) begin
         expected_total_in = LEN_READ_BASE + EXP_BITS'(b);
      end

      idx_plus2 = EXT_BITS'(byte_count_ff) + EXT_BITS'(2);
      idx_plus1 = EXT_BITS'(byte_count_ff) + EXT_BITS'(1);
      exp_ext   = EXT_BITS'(expected_total_in);

      // crc over payload, then catch the two trailing crc bytes
      if (byte_count_ff < COUNT_BITS'(2)) begin
         running_crc_in = crc_update(running_crc_ff, b);
      end else if (function_known_ff) begin
         priority if (idx_plus2 < exp_ext) begin
            running_crc_in = crc_update(running_crc_ff, b);
         end else if (idx_plus2 == exp_ext) begin
            crc_low_rx_in = b;
         end else if (idx_plus1 == exp_ext) begin
            crc_high_rx_in = b;
         end else begin
            // bytes past the crc are ignored
         end
      end

      // saturating count
      if (byte_count_ff != '1) begin
         byte_count_in = byte_count_ff + COUNT_BITS'(1);
      end

      count_ext = EXT_BITS'(byte_count_in);

      result_data.function_code = func_byte_in;
      result_data.extra_bytes   = 1'b0;
      priority if (count_ext < EXT_BITS'(LEN_MIN)) begin
         result_data.status = STATUS_TOO_SHORT;
      end else if (first_byte_in != slave_address) begin
         result_data.status = STATUS_BAD_ADDRESS;
      end else if (!function_known_in) begin
         result_data.status = STATUS_UNKNOWN_FC;
      end else if (exp_ext > count_ext) begin
         result_data.status = STATUS_MISSING;
      end else begin
         result_data.status = ({crc_high_rx_in, crc_low_rx_in} == running_crc_in)
                              ? STATUS_VALID : STATUS_CRC_ERROR;
         result_data.extra_bytes = (count_ext > exp_ext);
      end
   end

   assign result_valid = beat_accept && beat_data.last_byte;

   always_ff @(posedge clock) begin
      if (reset || (beat_accept && beat_data.last_byte)) begin
         byte_count_ff     <= '0;
         running_crc_ff    <= CRC_SEED;
         first_byte_ff     <= '0;
         func_byte_ff      <= '0;
         expected_total_ff <= '0;
         function_known_ff <= 1'b0;
         crc_low_rx_ff     <= '0;
         crc_high_rx_ff    <= '0;
      end else if (beat_accept) begin
         byte_count_ff     <= byte_count_in;
         running_crc_ff    <= running_crc_in;
         first_byte_ff     <= first_byte_in;
         func_byte_ff      <= func_byte_in;
         expected_total_ff <= expected_total_in;
         function_known_ff <= function_known_in;
         crc_low_rx_ff     <= crc_low_rx_in;
         crc_high_rx_ff    <= crc_high_rx_in;
      end
   end

endmodule

`default_nettype wire

### hdl/mrfc_rsp_queue.sv
// ---------------------------------------------------------------------------
// mrfc_rsp_queue: result register with skid stage
// Holds up to two verdict beats so input bytes keep flowing while one
// result waits on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module mrfc_rsp_queue
   import mrfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  rsp_beat_type push_data,
   output logic         has_room,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_beat_type rsp_data
);

   logic [1:0]   count_ff, count_in;
   rsp_beat_type out_ff, out_in;
   rsp_beat_type skid_ff, skid_in;
   logic         pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign has_room  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = out_ff;

   always_comb begin
      count_in = count_ff;
      out_in   = out_ff;
      skid_in  = skid_ff;
      unique case (count_ff)
         2'd0: begin
            if (push_valid) begin
               out_in   = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push_valid && pop) begin
               out_in = push_data;
            end else if (push_valid) begin
               skid_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            // full: no push can arrive
            if (pop) begin
               out_in   = skid_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire
